// ===== hdl/block_status_map_engine_assert.svh =====
// assertion macros for the block status map engine
`ifndef BLOCK_STATUS_MAP_ENGINE_ASSERT_SVH
`define BLOCK_STATUS_MAP_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BSME_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BSME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bsme_pkg.sv =====
package bsme_pkg;

  localparam logic [6:0] TYPE_MASK = 7'h0F;
  localparam logic [6:0] BAD_BIT   = 7'h10;
  localparam logic [6:0] DUP_BIT   = 7'h20;
  localparam logic [6:0] EATTR_BIT = 7'h40;

  localparam logic [4:0] KIND_BAD   = 5'd16;
  localparam logic [4:0] KIND_DUP   = 5'd17;
  localparam logic [4:0] KIND_EATTR = 5'd18;

  localparam logic [1:0] CMD_MARK  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_CHECK = 2'd2;
  localparam logic [1:0] CMD_FIND  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;

  localparam logic [16:0] BLOCK_COUNT_RST = 17'h10000;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  type_code;
    logic        bad_flag;
    logic        dup_flag;
    logic        eattr_flag;
    logic [15:0] found_block;
  } res_t;

  function automatic logic [6:0] flag_for_kind(input logic [4:0] kind);
    logic [6:0] f;
    f = 7'h00;
    if (kind == KIND_BAD) f = BAD_BIT;
    else if (kind == KIND_DUP) f = DUP_BIT;
    else if (kind == KIND_EATTR) f = EATTR_BIT;
    return f;
  endfunction

endpackage

// ===== hdl/block_status_map_engine.sv =====
// Block status map engine: one 7-bit record per block (type code, bad, duplicate and
// extended-attribute flags) held in a single-port synchronous memory of NUM_BLOCKS
// entries. After reset the memory is swept to zero, one entry per cycle, through all
// NUM_BLOCKS entries; in_ready stays low during the sweep, cfg writes are taken.
// Mark and clear read the entry, then modify it and write it back on the same port;
// check only reads it, and an out-of-range block gets a range status and no write.
// Find-next reads entries one per cycle, from the start block up to the first flagged
// block or the block limit. A finished result sits in the output register while the
// next item is accepted.
module block_status_map_engine #(
  parameter int NUM_BLOCKS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_block,
  input  logic [4:0]  in_mark_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_type_code,
  output logic        out_bad_flag,
  output logic        out_dup_flag,
  output logic        out_eattr_flag,
  output logic [15:0] out_found_block
);
  import bsme_pkg::*;
  `include "block_status_map_engine_assert.svh"

  localparam int AW = $clog2(NUM_BLOCKS);

  function automatic logic [AW-1:0] to_addr(input logic [16:0] i);
    logic [AW+16:0] w;
    w = {{AW{1'b0}}, i};
    return w[AW-1:0];
  endfunction

  logic [6:0]    mem [NUM_BLOCKS];
  logic [6:0]    rd_r;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_wa;
  logic [AW-1:0] mem_ra;
  logic [6:0]    mem_wd;

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [16:0]   blk_cnt_r;
  logic [16:0]   lim;
  logic [1:0]    cmd_r, cmd_nxt;
  logic [4:0]    kind_r, kind_nxt;
  logic [16:0]   idx_r, idx_nxt;
  logic          err_r, err_nxt;
  res_t          pend_r, pend_nxt;
  res_t          out_res_r, out_res_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          out_free;
  logic [16:0]   idx_inc;
  logic [6:0]    flag;
  res_t          res;
  logic          done;

  assign lim      = (32'(blk_cnt_r) > 32'(NUM_BLOCKS)) ? 17'(NUM_BLOCKS) : blk_cnt_r;
  assign out_free = !out_valid_r || out_ready;
  assign idx_inc  = idx_r + 17'd1;
  assign flag     = flag_for_kind(kind_r);
  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_cnt_r <= BLOCK_COUNT_RST;
    end else if (cfg_wr_en) begin
      blk_cnt_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    kind_r    <= kind_nxt;
    idx_r     <= idx_nxt;
    err_r     <= err_nxt;
    pend_r    <= pend_nxt;
    out_res_r <= out_res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    err_nxt       = err_r;
    pend_nxt      = pend_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_wa        = to_addr(idx_r);
    mem_ra        = to_addr(idx_r);
    mem_wd        = rd_r;
    res           = '0;
    done          = 1'b0;

    case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        mem_wd  = 7'h00;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(NUM_BLOCKS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          kind_nxt  = in_mark_kind;
          idx_nxt   = {1'b0, in_block};
          err_nxt   = ({1'b0, in_block} >= lim);
          mem_re    = 1'b1;
          mem_ra    = to_addr({1'b0, in_block});
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (err_r) begin
          res.status = ST_RANGE;
          done       = 1'b1;
        end else begin
          case (cmd_r)
            CMD_MARK: begin
              mem_we = 1'b1;
              if (!kind_r[4]) mem_wd = (rd_r & ~TYPE_MASK) | {3'b000, kind_r[3:0]};
              else mem_wd = rd_r | flag;
              res.status = ST_OK;
              done       = 1'b1;
            end
            CMD_CLEAR: begin
              mem_we = 1'b1;
              if (flag != 7'h00) mem_wd = rd_r & ~flag;
              else mem_wd = rd_r & ~TYPE_MASK;
              res.status = ST_OK;
              done       = 1'b1;
            end
            CMD_CHECK: begin
              res.status     = ST_OK;
              res.type_code  = rd_r[3:0];
              res.bad_flag   = |(rd_r & BAD_BIT);
              res.dup_flag   = |(rd_r & DUP_BIT);
              res.eattr_flag = |(rd_r & EATTR_BIT);
              done           = 1'b1;
            end
            default: begin
              if (kind_r != KIND_DUP && kind_r != KIND_EATTR) begin
                res.status = ST_NONE;
                done       = 1'b1;
              end else if ((rd_r & flag) != 7'h00) begin
                res.status      = ST_OK;
                res.found_block = idx_r[15:0];
                done            = 1'b1;
              end else if (idx_inc >= lim) begin
                res.status = ST_NONE;
                done       = 1'b1;
              end else begin
                mem_re  = 1'b1;
                mem_ra  = to_addr(idx_inc);
                idx_nxt = idx_inc;
              end
            end
          endcase
        end
        if (done) begin
          if (out_free) begin
            out_res_nxt   = res;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            pend_nxt  = res;
            state_nxt = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_res_nxt   = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_type_code   = out_res_r.type_code;
  assign out_bad_flag    = out_res_r.bad_flag;
  assign out_dup_flag    = out_res_r.dup_flag;
  assign out_eattr_flag  = out_res_r.eattr_flag;
  assign out_found_block = out_res_r.found_block;

  `BSME_ASSERT_NOW(a_no_accept_in_clear, state_r == S_CLEAR, !in_ready, "item accepted in sweep")
  `BSME_ASSERT_NOW(a_single_port, mem_we, !mem_re, "read and write in one cycle")
  `BSME_ASSERT_NOW(a_range_no_write, state_r == S_EXEC && err_r, !mem_we, "out-of-range write")
  `BSME_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_r == S_EXEC, "item not executed")
  `BSME_ASSERT_NOW(a_hold_full, state_r == S_HOLD, out_valid_r, "hold with empty output")

endmodule

// ===== sim/block_map_checker.sv =====
`timescale 1ns / 100ps

module block_map_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_block,
  input  logic [4:0]  in_mark_kind,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [3:0]  out_type_code,
  input  logic        out_bad_flag,
  input  logic        out_dup_flag,
  input  logic        out_eattr_flag,
  input  logic [15:0] out_found_block,
  output int          fail_count,
  output int          pending
);
  import bsme_pkg::*;

  localparam int unsigned MAP_DEPTH = 65536;

  logic [6:0]  shadow_map [MAP_DEPTH];
  logic [16:0] tracked_count;
  res_t        expected_replies [$];
  int          mismatches = 0;
  int          waiting = 0;

  assign fail_count = mismatches;
  assign pending    = waiting;

  function automatic res_t run_map_command(input logic [1:0] cmd, input logic [15:0] blk,
                                           input logic [4:0] kind);
    res_t        r;
    logic [6:0]  flag;
    logic [6:0]  rec;
    int unsigned lim;
    int unsigned idx;
    r = '0;
    lim = (tracked_count > MAP_DEPTH) ? MAP_DEPTH : 32'(tracked_count);
    case (kind)
      KIND_BAD:   flag = BAD_BIT;
      KIND_DUP:   flag = DUP_BIT;
      KIND_EATTR: flag = EATTR_BIT;
      default:    flag = 7'h00;
    endcase
    if (32'(blk) >= lim) begin
      r.status = ST_RANGE;
      return r;
    end
    rec = shadow_map[blk];
    case (cmd)
      CMD_MARK: begin
        if (kind < KIND_BAD) rec[3:0] = kind[3:0];
        else rec = rec | flag;
        shadow_map[blk] = rec;
        r.status = ST_OK;
      end
      CMD_CLEAR: begin
        if (flag != 7'h00) rec = rec & ~flag;
        else rec[3:0] = 4'h0;
        shadow_map[blk] = rec;
        r.status = ST_OK;
      end
      CMD_CHECK: begin
        r.status     = ST_OK;
        r.type_code  = rec[3:0];
        r.bad_flag   = rec[4];
        r.dup_flag   = rec[5];
        r.eattr_flag = rec[6];
      end
      default: begin
        r.status = ST_NONE;
        if (kind == KIND_DUP || kind == KIND_EATTR) begin
          for (idx = 32'(blk); idx < lim; idx++) begin
            if ((shadow_map[idx] & flag) != 7'h00) begin
              r.status      = ST_OK;
              r.found_block = idx[15:0];
              break;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    int   i;
    if (!rst_n) begin
      tracked_count = BLOCK_COUNT_RST;
      expected_replies.delete();
      for (i = 0; i < MAP_DEPTH; i++) shadow_map[i] = 7'h00;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected result item, status %0d", out_status);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("type_code", 32'(want.type_code), 32'(out_type_code));
          check_field("bad_flag", 32'(want.bad_flag), 32'(out_bad_flag));
          check_field("dup_flag", 32'(want.dup_flag), 32'(out_dup_flag));
          check_field("eattr_flag", 32'(want.eattr_flag), 32'(out_eattr_flag));
          check_field("found_block", 32'(want.found_block), 32'(out_found_block));
        end
      end
      if (cfg_wr_en) tracked_count = cfg_wr_data;
      if (in_valid && in_ready)
        expected_replies.push_back(run_map_command(in_cmd, in_block, in_mark_kind));
    end
    waiting = expected_replies.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import bsme_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [16:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic [15:0] in_block;
  logic [4:0]  in_mark_kind;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [3:0]  out_type_code;
  logic        out_bad_flag;
  logic        out_dup_flag;
  logic        out_eattr_flag;
  logic [15:0] out_found_block;
  int          fail_count;
  int          pending;
  int          hold_reqs = 0;
  int          burst_left = 0;
  int          steady_left = 0;

  int unsigned phase_counts [8] = '{64, 0, 131071, 1, 200, 65535, 65536, 33};
  int          phase_items [8]  = '{90, 20, 90, 40, 90, 90, 90, 90};

  always #5 clk = ~clk;

  block_status_map_engine dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_block       (in_block),
    .in_mark_kind   (in_mark_kind),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_type_code  (out_type_code),
    .out_bad_flag   (out_bad_flag),
    .out_dup_flag   (out_dup_flag),
    .out_eattr_flag (out_eattr_flag),
    .out_found_block(out_found_block)
  );

  block_map_checker map_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_block       (in_block),
    .in_mark_kind   (in_mark_kind),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_type_code  (out_type_code),
    .out_bad_flag   (out_bad_flag),
    .out_dup_flag   (out_dup_flag),
    .out_eattr_flag (out_eattr_flag),
    .out_found_block(out_found_block),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  task automatic push_item(input logic [1:0] c, input logic [15:0] b, input logic [4:0] k);
    int gap;
    if (steady_left > 0) begin
      steady_left--;
    end else if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid     = 1'b1;
    in_cmd       = c;
    in_block     = b;
    in_mark_kind = k;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_count(input logic [16:0] value);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  initial begin : receiver
    int mode;
    int mode_left;
    int holds_done;
    mode       = 0;
    mode_left  = 0;
    holds_done = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        // hold off long enough for the input side to back up
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
        holds_done++;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 40);
      end
      mode_left--;
      case (mode)
        0:       out_ready = 1'b1;
        1:       out_ready = 1'($urandom_range(0, 1));
        default: out_ready = ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  initial begin
    #(20_000_000);
    $display("block_status_map_engine test failed");
    $finish;
  end

  initial begin
    int unsigned lim;
    logic [1:0]  c;
    logic [15:0] b;
    logic [4:0]  k;
    int          sel;
    int          guard;
    int          p;
    int          n;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    in_cmd       = CMD_MARK;
    in_block     = '0;
    in_mark_kind = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    push_item(CMD_CHECK, 16'h0000, 5'd0);
    push_item(CMD_CHECK, 16'hFFFF, 5'd31);
    push_item(CMD_MARK, 16'h0000, 5'd15);
    push_item(CMD_MARK, 16'h0000, KIND_BAD);
    push_item(CMD_MARK, 16'h0000, KIND_DUP);
    push_item(CMD_MARK, 16'hFFFF, KIND_EATTR);
    push_item(CMD_MARK, 16'h0005, 5'd25);
    push_item(CMD_CHECK, 16'h0000, 5'd0);
    push_item(CMD_CHECK, 16'h0005, 5'd0);
    push_item(CMD_FIND, 16'h0000, KIND_DUP);
    push_item(CMD_FIND, 16'h0001, KIND_EATTR);
    push_item(CMD_FIND, 16'h0001, KIND_DUP);
    push_item(CMD_FIND, 16'h0000, KIND_BAD);
    push_item(CMD_FIND, 16'h0000, 5'd0);
    push_item(CMD_CLEAR, 16'h0000, KIND_BAD);
    push_item(CMD_CLEAR, 16'h0000, 5'd31);
    push_item(CMD_CHECK, 16'h0000, 5'd0);
    push_item(CMD_CLEAR, 16'hFFFF, KIND_EATTR);
    push_item(CMD_CLEAR, 16'h0003, KIND_DUP);
    push_item(CMD_MARK, 16'hAAAA, 5'd10);
    push_item(CMD_MARK, 16'h5555, 5'd5);
    push_item(CMD_CHECK, 16'hAAAA, 5'd0);
    push_item(CMD_CHECK, 16'h5555, 5'd0);
    push_item(CMD_FIND, 16'hFFFF, KIND_DUP);

    for (p = 0; p < 8; p++) begin
      drain();
      write_count(17'(phase_counts[p]));
      lim = (phase_counts[p] > 65536) ? 65536 : phase_counts[p];
      // plant flags just above the low window so scans stay short
      if (lim >= 65535) begin
        push_item(CMD_MARK, 16'd64, KIND_DUP);
        push_item(CMD_MARK, 16'd64, KIND_EATTR);
      end
      if (lim > 0) push_item(CMD_CHECK, 16'(lim - 1), 5'd0);
      if (lim < 65536) push_item(CMD_CHECK, 16'(lim), 5'd0);
      for (n = 0; n < phase_items[p]; n++) begin
        if (n == phase_items[p] / 2) begin
          if (p % 2 == 0) begin
            hold_reqs++;
            steady_left = 16;
          end else begin
            drain();
          end
        end
        c   = 2'($urandom_range(0, 3));
        sel = $urandom_range(0, 19);
        if (c == CMD_FIND)
          k = (sel < 14) ? ((sel % 2 == 1) ? KIND_DUP : KIND_EATTR) : 5'($urandom_range(0, 31));
        else if (sel < 8)
          k = 5'($urandom_range(16, 18));
        else if (sel < 17)
          k = 5'($urandom_range(0, 15));
        else
          k = 5'($urandom_range(19, 31));
        sel = $urandom_range(0, 9);
        if (lim >= 65535) begin
          if (sel < 6 || (sel == 9 && c == CMD_FIND)) b = 16'($urandom_range(0, 63));
          else if (sel < 9) b = 16'($urandom_range(65472, 65535));
          else b = 16'($urandom);
        end else if (sel < 7) begin
          b = 16'($urandom_range(0, lim + 3));
        end else begin
          b = 16'($urandom);
        end
        push_item(c, b, k);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    guard = 0;
    while (pending != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("block_status_map_engine test passed");
    else
      $display("block_status_map_engine test failed");
    $finish;
  end

endmodule
